@@ design/ssp_pkg.sv @@
// Shared types and constants for the signature string parser.
// No dependencies; imported by signature_string_parser.
package ssp_pkg;

    localparam int MAX_ORDER_DEF = 26;
    localparam int FIFO_DEPTH    = 4;
    localparam int MAX_RESULTS   = 3;

    localparam logic [5:0] POS_SAT   = 6'd52;
    localparam logic [5:0] TOTAL_SAT = 6'd63;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam logic [1:0] KIND_LABEL   = 2'd0;
    localparam logic [1:0] KIND_CYCLE   = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [1:0] ST_VALID     = 2'd0;
    localparam logic [1:0] ST_NO_LETTER = 2'd1;
    localparam logic [1:0] ST_MISMATCH  = 2'd2;
    localparam logic [1:0] ST_OVERUSE   = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] position;
        logic [4:0] letter;
        logic       inverted;
        logic [5:0] cycle_index;
        logic [5:0] cycle_length;
        logic       new_group;
        logic [1:0] status;
        logic [4:0] order;
        logic [5:0] cycle_count;
        logic [5:0] group_count;
        logic       last_result;
    } result_t;

endpackage

@@ design/signature_string_parser.sv @@
// Signature string parser top level: input register, parse logic, result queue.
// Depends on ssp_pkg for result layout, character codes and result codes.

// The block takes a signature string one byte per transfer on the input
// channel, with last set on the final byte, and streams out label, cycle and
// summary results on the output channel. An accepted byte sits in an input
// register; there one pass of compare and counter logic works out every
// result it causes (at most three: a label, a cycle close and the summary)
// and writes them together into a four-entry result queue once the queue has
// room, while the parser state is updated, or cleared after the last byte.
// The input register is refilled in the same cycle it is consumed, so a byte
// can be taken every cycle. While the receiver is ready the output port
// delivers one result per cycle, so the sustained rate is one byte per cycle
// as long as bytes cause one result or none on average; a byte causing k
// results needs k output transfers, and the input stalls only while the
// queue lacks room for three results. Results pass from the input register
// through the queue; whitespace bytes that are not last produce no result at all.
module signature_string_parser
    import ssp_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [5:0] position,
    output logic [4:0] letter,
    output logic       inverted,
    output logic [5:0] cycle_index,
    output logic [5:0] cycle_length,
    output logic       new_group,
    output logic [1:0] status,
    output logic [4:0] order,
    output logic [5:0] cycle_count,
    output logic [5:0] group_count,
    output logic       last_result
);

    localparam int IDX_W = $clog2(MAX_ORDER);
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int NUM_W = $clog2(MAX_RESULTS + 1);

    // Input register.
    logic       stage_valid_reg, stage_valid_next;
    logic [7:0] char_reg;
    logic       last_reg;

    // Parser state.
    logic [1:0] use_count_reg  [MAX_ORDER];
    logic [1:0] use_count_next [MAX_ORDER];
    logic [5:0] total_reg,   total_next;
    logic [4:0] largest_reg, largest_next;
    logic       any_reg,     any_next;
    logic [5:0] pos_reg,     pos_next;
    logic [5:0] begin_reg,   begin_next;
    logic [5:0] cycles_reg,  cycles_next;
    logic [5:0] prev_len_reg, prev_len_next;
    logic [5:0] groups_reg,  groups_next;
    logic       overuse_reg, overuse_next;

    // Result queue.
    result_t            fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    // Parse signals.
    logic             is_upper, is_lower, is_letter, is_space, is_sep;
    logic [7:0]       offset;
    logic [4:0]       idx;
    logic [1:0]       uc_cur;
    logic             idx_ok;
    logic [5:0]       pos_after;
    logic             close_en;
    logic [5:0]       len;
    logic             fresh;
    logic [4:0]       ord;
    logic [1:0]       st;
    result_t          res [MAX_RESULTS];
    logic [NUM_W-1:0] num_res;
    logic             pop, stage_go, room;
    logic [CNT_W-1:0] count_eff;

    // Character classes.
    assign is_upper  = (char_reg >= CH_UPPER_A) && (char_reg <= CH_UPPER_Z);
    assign is_lower  = (char_reg >= CH_LOWER_A) && (char_reg <= CH_LOWER_Z);
    assign is_letter = is_upper || is_lower;
    assign is_space  = (char_reg == CH_SPACE) || ((char_reg >= CH_TAB) && (char_reg <= CH_CR));
    assign is_sep    = !is_letter && !is_space;
    assign offset    = is_upper ? (char_reg - CH_UPPER_A) : (char_reg - CH_LOWER_A);
    assign idx       = offset[4:0];
    assign idx_ok    = ({27'd0, idx} < 32'(MAX_ORDER));
    assign uc_cur    = idx_ok ? use_count_reg[idx[IDX_W-1:0]] : 2'd0;

    // Handshake: the stage fires when the queue can take three more results,
    // counting the entry that leaves this cycle.
    assign pop       = out_valid && out_ready;
    assign count_eff = count_reg - CNT_W'(pop);
    assign room      = (count_eff <= CNT_W'(FIFO_DEPTH - MAX_RESULTS));
    assign stage_go  = stage_valid_reg && room;
    assign in_ready  = !stage_valid_reg || stage_go;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_ready)
        begin
            stage_valid_next = in_valid;
        end
    end

    // Parse pass: results and next state for the byte in the input register.
    always_comb
    begin
        for (int i = 0; i < MAX_ORDER; i++)
        begin
            use_count_next[i] = use_count_reg[i];
        end
        total_next    = total_reg;
        largest_next  = largest_reg;
        any_next      = any_reg;
        pos_next      = pos_reg;
        begin_next    = begin_reg;
        cycles_next   = cycles_reg;
        prev_len_next = prev_len_reg;
        groups_next   = groups_reg;
        overuse_next  = overuse_reg;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res[i] = '0;
        end
        num_res = '0;

        // Letter label.
        if (is_letter)
        begin
            res[0].kind     = KIND_LABEL;
            res[0].position = pos_reg;
            res[0].letter   = idx;
            res[0].inverted = is_upper;
            num_res         = NUM_W'(1);
            if (idx_ok)
            begin
                if (uc_cur >= 2'd2)
                begin
                    overuse_next = 1'b1;
                end
                if (uc_cur != 2'd3)
                begin
                    use_count_next[idx[IDX_W-1:0]] = uc_cur + 2'd1;
                end
            end
            if (total_reg < TOTAL_SAT)
            begin
                total_next = total_reg + 6'd1;
            end
            if (!any_reg || (idx > largest_reg))
            begin
                largest_next = idx;
            end
            any_next = 1'b1;
            if (pos_reg < POS_SAT)
            begin
                pos_next = pos_reg + 6'd1;
            end
        end
        pos_after = pos_next;

        // Cycle close: a separator closes the open cycle, and so does the
        // last byte after its own letter has been counted.
        close_en = (is_sep || last_reg) && (begin_reg < pos_after);
        len      = pos_after - begin_reg;
        fresh    = (cycles_reg == 6'd0) || (len != prev_len_reg);
        if (close_en)
        begin
            res[num_res].kind         = KIND_CYCLE;
            res[num_res].cycle_index  = cycles_reg;
            res[num_res].cycle_length = len;
            res[num_res].new_group    = fresh;
            num_res                   = num_res + NUM_W'(1);
            if (cycles_reg < POS_SAT)
            begin
                cycles_next = cycles_reg + 6'd1;
            end
            if (fresh && (groups_reg < POS_SAT))
            begin
                groups_next = groups_reg + 6'd1;
            end
            prev_len_next = len;
            begin_next    = pos_after;
        end

        // Summary on the last byte; status checks run in priority order.
        ord = any_next ? (largest_next + 5'd1) : 5'd0;
        if (!any_next)
        begin
            st = ST_NO_LETTER;
        end
        else if (total_next != {ord, 1'b0})
        begin
            st = ST_MISMATCH;
        end
        else if (overuse_next)
        begin
            st = ST_OVERUSE;
        end
        else
        begin
            st = ST_VALID;
        end
        if (last_reg)
        begin
            res[num_res].kind        = KIND_SUMMARY;
            res[num_res].status      = st;
            res[num_res].order       = ord;
            res[num_res].cycle_count = cycles_next;
            res[num_res].group_count = groups_next;
            num_res                  = num_res + NUM_W'(1);
            for (int i = 0; i < MAX_ORDER; i++)
            begin
                use_count_next[i] = 2'd0;
            end
            total_next    = '0;
            largest_next  = '0;
            any_next      = 1'b0;
            pos_next      = '0;
            begin_next    = '0;
            cycles_next   = '0;
            prev_len_next = '0;
            groups_next   = '0;
            overuse_next  = 1'b0;
        end

        if (num_res != '0)
        begin
            res[num_res - NUM_W'(1)].last_result = 1'b1;
        end
    end

    // Queue pointers.
    always_comb
    begin
        head_next  = head_reg + PTR_W'(pop);
        tail_next  = tail_reg;
        count_next = count_eff;
        if (stage_go)
        begin
            tail_next  = tail_reg + PTR_W'(num_res);
            count_next = count_eff + CNT_W'(num_res);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            for (int i = 0; i < MAX_ORDER; i++)
            begin
                use_count_reg[i] <= 2'd0;
            end
            total_reg    <= '0;
            largest_reg  <= '0;
            any_reg      <= 1'b0;
            pos_reg      <= '0;
            begin_reg    <= '0;
            cycles_reg   <= '0;
            prev_len_reg <= '0;
            groups_reg   <= '0;
            overuse_reg  <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            count_reg       <= count_next;
            if (stage_go)
            begin
                for (int i = 0; i < MAX_ORDER; i++)
                begin
                    use_count_reg[i] <= use_count_next[i];
                end
                total_reg    <= total_next;
                largest_reg  <= largest_next;
                any_reg      <= any_next;
                pos_reg      <= pos_next;
                begin_reg    <= begin_next;
                cycles_reg   <= cycles_next;
                prev_len_reg <= prev_len_next;
                groups_reg   <= groups_next;
                overuse_reg  <= overuse_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= char_code;
            last_reg <= last;
        end
        if (stage_go)
        begin
            for (int k = 0; k < MAX_RESULTS; k++)
            begin
                if (NUM_W'(k) < num_res)
                begin
                    fifo_mem[tail_reg + PTR_W'(k)] <= res[k];
                end
            end
        end
    end

    // Output side reads the queue head.
    assign out_valid    = (count_reg != '0);
    assign kind         = fifo_mem[head_reg].kind;
    assign position     = fifo_mem[head_reg].position;
    assign letter       = fifo_mem[head_reg].letter;
    assign inverted     = fifo_mem[head_reg].inverted;
    assign cycle_index  = fifo_mem[head_reg].cycle_index;
    assign cycle_length = fifo_mem[head_reg].cycle_length;
    assign new_group    = fifo_mem[head_reg].new_group;
    assign status       = fifo_mem[head_reg].status;
    assign order        = fifo_mem[head_reg].order;
    assign cycle_count  = fifo_mem[head_reg].cycle_count;
    assign group_count  = fifo_mem[head_reg].group_count;
    assign last_result  = fifo_mem[head_reg].last_result;

    // The queue never holds more entries than it has.
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    // After the last byte of a string the parser state starts from zero.
    a_string_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_go && last_reg) |=> (pos_reg == 6'd0 && cycles_reg == 6'd0 && !any_reg))
        else $error("parser state not cleared after last byte");

    // A stalled input means a byte is waiting for queue space.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (stage_valid_reg && !room))
        else $error("input stalled without a waiting byte");

    // A summary is always the final result of its byte.
    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_SUMMARY) |-> last_result)
        else $error("summary result without last_result");

endmodule

@@ bench/ssp_result_checker.sv @@
// Result checker for the signature string parser: watches both channels,
// predicts the result stream per accepted byte and compares it field by field.
// Depends on ssp_pkg for the result layout, character codes and result codes.
`timescale 1ns / 100ps

module ssp_result_checker
    import ssp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       last,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [1:0] kind,
    input  logic [5:0] position,
    input  logic [4:0] letter,
    input  logic       inverted,
    input  logic [5:0] cycle_index,
    input  logic [5:0] cycle_length,
    input  logic       new_group,
    input  logic [1:0] status,
    input  logic [4:0] order,
    input  logic [5:0] cycle_count,
    input  logic [5:0] group_count,
    input  logic       last_result,
    output int         fail_count,
    output int         results_checked,
    output int         pending
);

    // Parser state as the predictor sees it.
    logic [1:0] letter_uses [MAX_ORDER_DEF];
    logic [5:0] letters_counted;
    logic [4:0] top_letter;
    logic       saw_letter;
    logic [5:0] next_pos;
    logic [5:0] open_from;
    logic [5:0] cycles_closed;
    logic [5:0] prev_len;
    logic [5:0] groups_seen;
    logic       third_use;

    result_t expected_results[$];
    result_t step_results[$];
    int      mismatch_total = 0;
    int      checked_total = 0;

    function automatic result_t blank_result(input logic [1:0] k);
        result_t r;
        r = '0;
        r.kind = k;
        return r;
    endfunction

    task automatic clear_parser();
        foreach (letter_uses[i]) letter_uses[i] = 2'd0;
        letters_counted = '0;
        top_letter      = '0;
        saw_letter      = 1'b0;
        next_pos        = '0;
        open_from       = '0;
        cycles_closed   = '0;
        prev_len        = '0;
        groups_seen     = '0;
        third_use       = 1'b0;
    endtask

    // A cycle is only reported when it holds at least one letter.
    task automatic close_open_cycle();
        result_t    r;
        logic [5:0] len;
        logic       fresh;
        if (open_from < next_pos) begin
            len   = next_pos - open_from;
            fresh = (cycles_closed == 0) || (len != prev_len);
            r = blank_result(KIND_CYCLE);
            r.cycle_index  = cycles_closed;
            r.cycle_length = len;
            r.new_group    = fresh;
            step_results.push_back(r);
            if (cycles_closed < POS_SAT) cycles_closed++;
            if (fresh && groups_seen < POS_SAT) groups_seen++;
            prev_len  = len;
            open_from = next_pos;
        end
    endtask

    task automatic predict_byte(input logic [7:0] c, input logic fin);
        result_t    r;
        logic       upper;
        logic [4:0] idx;
        logic [4:0] ord;
        step_results.delete();
        upper = (c >= CH_UPPER_A && c <= CH_UPPER_Z);
        if (upper || (c >= CH_LOWER_A && c <= CH_LOWER_Z)) begin
            idx = upper ? 5'(c - CH_UPPER_A) : 5'(c - CH_LOWER_A);
            r = blank_result(KIND_LABEL);
            r.position = next_pos;
            r.letter   = idx;
            r.inverted = upper;
            step_results.push_back(r);
            if (letter_uses[idx] >= 2'd2) third_use = 1'b1;
            if (letter_uses[idx] != 2'd3) letter_uses[idx]++;
            if (letters_counted < TOTAL_SAT) letters_counted++;
            if (!saw_letter || idx > top_letter) top_letter = idx;
            saw_letter = 1'b1;
            if (next_pos < POS_SAT) next_pos++;
        end else if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
            close_open_cycle();
        end
        if (fin) begin
            close_open_cycle();
            ord = saw_letter ? top_letter + 5'd1 : 5'd0;
            r = blank_result(KIND_SUMMARY);
            if (!saw_letter)
                r.status = ST_NO_LETTER;
            else if (int'(letters_counted) != 2 * int'(ord))
                r.status = ST_MISMATCH;
            else if (third_use)
                r.status = ST_OVERUSE;
            else
                r.status = ST_VALID;
            r.order       = ord;
            r.cycle_count = cycles_closed;
            r.group_count = groups_seen;
            step_results.push_back(r);
            clear_parser();
        end
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last_result = 1'b1;
        foreach (step_results[i]) expected_results.push_back(step_results[i]);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_total++;
        $display("%0t checker: %s got %0d expected %0d (result %0d)",
                 $time, what, got, want, checked_total);
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want) report_mismatch(what, got, want);
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (expected_results.size() == 0) begin
            report_mismatch("unexpected result, kind", got.kind, -1);
        end else begin
            want = expected_results.pop_front();
            check_field("kind", got.kind, want.kind);
            check_field("position", got.position, want.position);
            check_field("letter", got.letter, want.letter);
            check_field("inverted", got.inverted, want.inverted);
            check_field("cycle_index", got.cycle_index, want.cycle_index);
            check_field("cycle_length", got.cycle_length, want.cycle_length);
            check_field("new_group", got.new_group, want.new_group);
            check_field("status", got.status, want.status);
            check_field("order", got.order, want.order);
            check_field("cycle_count", got.cycle_count, want.cycle_count);
            check_field("group_count", got.group_count, want.group_count);
            check_field("last_result", got.last_result, want.last_result);
        end
        checked_total++;
    endtask

    initial clear_parser();

    // The counters go out by nonblocking assignment, so the top always reads
    // the values left by the previous edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready)
                check_result('{kind, position, letter, inverted, cycle_index, cycle_length,
                               new_group, status, order, cycle_count, group_count,
                               last_result});
            if (in_valid && in_ready)
                predict_byte(char_code, last);
        end
        fail_count      <= mismatch_total;
        results_checked <= checked_total;
        pending         <= expected_results.size();
    end

endmodule

@@ bench/signature_string_parser_tb.sv @@
// Testbench top for the signature string parser: clock, reset, byte stimulus
// and output back-pressure. Depends on ssp_pkg, the block and ssp_result_checker.
`timescale 1ns / 100ps

module signature_string_parser_tb;
    import ssp_pkg::*;

    typedef logic [7:0] byte_list_t[$];

    // Stimulus stops once this many bytes have been transferred.
    localparam int ITEM_TARGET = 330;
    // Watchdog limit, far beyond what a slow correct run needs.
    localparam int CYCLE_LIMIT = 200000;
    // Length of the single long receiver hold-off.
    localparam int HOLD_CYCLES = 150;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] char_code = 8'h00;
    logic       last = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] kind;
    logic [5:0] position;
    logic [4:0] letter;
    logic       inverted;
    logic [5:0] cycle_index;
    logic [5:0] cycle_length;
    logic       new_group;
    logic [1:0] status;
    logic [4:0] order;
    logic [5:0] cycle_count;
    logic [5:0] group_count;
    logic       last_result;

    int   fail_count;
    int   results_checked;
    int   pending;

    // Asks the receiver process for its long hold-off.
    logic stall_req = 1'b0;

    int   bytes_sent = 0;
    int   strings_sent = 0;
    int   burst_left = 0;
    bit   idle_enable = 1'b1;
    int   cycles_run = 0;

    signature_string_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_code    (char_code),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .position     (position),
        .letter       (letter),
        .inverted     (inverted),
        .cycle_index  (cycle_index),
        .cycle_length (cycle_length),
        .new_group    (new_group),
        .status       (status),
        .order        (order),
        .cycle_count  (cycle_count),
        .group_count  (group_count),
        .last_result  (last_result)
    );

    // The checker sits beside the block and sees exactly what it sees.
    ssp_result_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .char_code       (char_code),
        .last            (last),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .position        (position),
        .letter          (letter),
        .inverted        (inverted),
        .cycle_index     (cycle_index),
        .cycle_length    (cycle_length),
        .new_group       (new_group),
        .status          (status),
        .order           (order),
        .cycle_count     (cycle_count),
        .group_count     (group_count),
        .last_result     (last_result),
        .fail_count      (fail_count),
        .results_checked (results_checked),
        .pending         (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles_run++;
        if (cycles_run >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycles_run, pending);
            $display("[signature_string_parser] ERROR");
            $finish;
        end
    end

    // The receiver cycles through its own stall patterns in turn: always ready,
    // coin flip, mostly stalled and mostly ready. When the stimulus asks for it,
    // it first holds off for one long stretch while the sender keeps offering
    // bytes, so the result queue fills up and the input side has to stall.
    initial
    begin : receiver_pattern
        int tick;
        int hold_left;
        bit hold_taken;
        tick = 0;
        hold_left = 0;
        hold_taken = 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (stall_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case ((tick / 97) % 4)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ((tick % 5) != 0);
                endcase
            end
        end
    end

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [7:0] letter_byte(input int idx, input bit upper);
        return upper ? 8'(CH_UPPER_A + idx) : 8'(CH_LOWER_A + idx);
    endfunction

    // Any byte that closes a cycle, high bytes and control codes included.
    function automatic logic [7:0] pick_separator();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (is_letter(c) || is_blank(c));
        return c;
    endfunction

    function automatic logic [7:0] pick_blank();
        if ($urandom_range(0, 2) == 0)
            return CH_SPACE;
        return 8'(CH_TAB + $urandom_range(0, 4));
    endfunction

    function automatic byte_list_t from_text(input string t);
        byte_list_t s;
        for (int i = 0; i < t.len(); i++)
            s.push_back(t[i]);
        return s;
    endfunction

    // Builds a signature over the first n letters, each used twice, in random
    // order and case. A flaw drops a letter, adds a third use, or adds a
    // letter beyond the order. Cycles are cut at a fixed period or at random.
    function automatic byte_list_t make_signature(input int n, input int flaw);
        byte_list_t s;
        int pool[$];
        int j;
        int tmp;
        int period;
        for (int i = 0; i < n; i++)
        begin
            pool.push_back(i);
            pool.push_back(i);
        end
        if (flaw == 1)
            pool.delete($urandom_range(0, pool.size() - 1));
        else if (flaw == 2 || (flaw == 3 && n >= MAX_ORDER_DEF))
            pool.push_back(pool[$urandom_range(0, pool.size() - 1)]);
        else if (flaw == 3)
            pool.push_back($urandom_range(n, MAX_ORDER_DEF - 1));
        for (int i = pool.size() - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = pool[i];
            pool[i] = pool[j];
            pool[j] = tmp;
        end
        period = $urandom_range(0, 3);
        for (int i = 0; i < pool.size(); i++)
        begin
            if (period == 0 ? $urandom_range(0, 3) == 0 : (i > 0 && i % period == 0))
                s.push_back(pick_separator());
            if ($urandom_range(0, 7) == 0)
                s.push_back(pick_blank());
            s.push_back(letter_byte(pool[i], 1'($urandom_range(0, 1))));
        end
        if ($urandom_range(0, 1) == 0)
            s.push_back(pick_separator());
        return s;
    endfunction

    // Overlong strings drive the position, cycle and letter counters into
    // saturation.
    function automatic byte_list_t make_overlong(input int count, input bit chopped);
        byte_list_t s;
        for (int i = 0; i < count; i++)
        begin
            s.push_back(letter_byte($urandom_range(0, MAX_ORDER_DEF - 1),
                                    1'($urandom_range(0, 1))));
            if (chopped)
                s.push_back(pick_separator());
        end
        return s;
    endfunction

    // Offers one byte. The sender works in bursts; between bursts it may drop
    // valid for a random gap, unless idling is switched off for the phase.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if (idle_enable && $urandom_range(0, 3) != 0)
            begin
                gap = $urandom_range(1, 8);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        char_code <= b;
        last      <= fin;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_string(input byte_list_t s);
        foreach (s[i]) send_byte(s[i], i == s.size() - 1);
        strings_sent++;
    endtask

    // Drops valid and waits until every predicted result has come back. The
    // first edge is always taken, so the checker's count already includes
    // the byte just transferred.
    task automatic drain_results();
        in_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    initial
    begin : stimulus
        int pick;
        bit paused;
        paused = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings. A valid signature with mixed case whose cycles
        // have equal length, so the second does not open a new group.
        send_string(from_text("aB.Ab"));
        // A lone whitespace byte marked last gives only a no-letter summary.
        send_string('{CH_TAB});
        // Separators and a blank with no letters between them give no cycle; the high
        // byte ends a string with no letters.
        send_string('{8'h00, CH_CR, 8'hFF});
        // The highest letter in both cases: order 26 with only two letters.
        send_string(from_text("zZ"));
        // A third use of one letter while the count happens to match.
        send_string(from_text("aaab"));
        // A high-byte separator, then a trailing space that closes the last
        // cycle with a different length.
        send_string('{8'h61, 8'h62, 8'h80, 8'h63, CH_SPACE});
        // Bytes just outside the letter ranges act as separators.
        send_string(from_text("@[`{"));

        // The receiver's long hold-off starts as the random part begins,
        // while the sender keeps offering bytes.
        stall_req <= 1'b1;
        send_string(make_overlong(60, 1'b1));
        send_string(make_overlong(66, 1'b0));

        while (bytes_sent < ITEM_TARGET)
        begin
            // One phase in the middle runs without any sender idling.
            idle_enable = !(bytes_sent > 200 && bytes_sent < 260);
            if (!paused && bytes_sent > 160)
            begin
                paused = 1'b1;
                drain_results();
            end
            pick = $urandom_range(0, 99);
            if (pick < 65)
                send_string(make_signature($urandom_range(0, 9) == 0 ?
                    $urandom_range(7, MAX_ORDER_DEF) : $urandom_range(1, 6), 0));
            else if (pick < 85)
                send_string(make_signature($urandom_range(1, 6), $urandom_range(1, 3)));
            else
            begin
                byte_list_t noise;
                noise.delete();
                repeat ($urandom_range(1, 6)) noise.push_back(8'($urandom_range(0, 255)));
                send_string(noise);
            end
        end

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        // Leave ample room for any stray result.
        repeat (20) @(posedge clk);

        $display("Sent %0d strings in %0d byte transfers; %0d results checked.",
                 strings_sent, bytes_sent, results_checked);
        $display("Covered valid, malformed, noisy and overlong strings under back-pressure.");
        if (fail_count == 0 && pending == 0)
            $display("[signature_string_parser] OK");
        else
            $display("[signature_string_parser] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
design/ssp_pkg.sv
design/signature_string_parser.sv
bench/ssp_result_checker.sv
bench/signature_string_parser_tb.sv
